// File: rtl/sbh_pkg.sv
package sbh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } state_t;

  localparam int BlockWords = 16;
  localparam int ChainWords = 8;
  localparam int Rounds     = 64;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [ChainWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

// File: rtl/sbh_ram.sv
module sbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sha256_byte_stream_hasher.sv
// channel | dir | payload            | handshake
// msg     | in  | sbh_pkg::msg_t     | msg_valid / msg_stall
// dig     | out | sbh_pkg::dig_t     | dig_valid / dig_stall
//
// A byte is taken per cycle when idle; the byte that fills a block holds the input
// while the block and chain memories are read, the 64 rounds run and the chain is updated.
// End of message: one cycle per pad byte (9 to 72), one or two compressions, then OUT_RD,
// OUT_LD and OUT_HOLD per word plus any output stall; the chain memory port sets this pace.
// After reset a sweep writes the initial hash values; the input is held meanwhile.
// msg_stall is high whenever the block is not idle; a stalled digest word holds.
module sha256_byte_stream_hasher (
  input  logic          clk,
  input  logic          rst,
  input  logic          msg_valid,
  output logic          msg_stall,
  input  sbh_pkg::msg_t msg,
  output logic          dig_valid,
  input  logic          dig_stall,
  output sbh_pkg::dig_t dig
);

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  sbh_pkg::state_t state, state_next;
  logic [5:0]  cnt, cnt_next;
  logic [5:0]  fill;
  logic [63:0] len;
  logic [23:0] pend;
  logic        marked, len_phase, finishing;
  logic [2:0]  oc;
  logic        rd_vld;
  logic [3:0]  rd_idx;
  logic [31:0] v [8];
  logic [31:0] w [16];

  logic        absorb;
  logic [7:0]  absorb_byte;
  logic        pad_mark, pad_len;

  logic        blk_we;
  logic [31:0] blk_rdata;
  logic        ch_we;
  logic [2:0]  ch_waddr, ch_raddr;
  logic [31:0] ch_wdata, ch_rdata;

  logic [31:0] t1, t2, w_new;

  assign blk_we = absorb && (fill[1:0] == 2'b11);

  sbh_ram #(.WIDTH(32), .DEPTH(sbh_pkg::BlockWords)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (fill[5:2]),
    .wdata ({pend, absorb_byte}),
    .raddr (cnt[3:0]),
    .rdata (blk_rdata)
  );

  sbh_ram #(.WIDTH(32), .DEPTH(sbh_pkg::ChainWords)) u_chain_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
              + sbh_pkg::ROUND_K[cnt] + w[0];
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign w_new = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbh_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    msg_stall   = (state != sbh_pkg::ST_IDLE);
    absorb      = 1'b0;
    absorb_byte = msg.data_byte;
    pad_mark    = 1'b0;
    pad_len     = 1'b0;
    ch_we       = 1'b0;
    ch_waddr    = cnt[2:0];
    ch_wdata    = sbh_pkg::INIT_H[cnt[2:0]];
    ch_raddr    = cnt[2:0];
    case (state)
      sbh_pkg::ST_INIT: begin
        ch_we    = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd7) begin
          cnt_next   = '0;
          state_next = sbh_pkg::ST_IDLE;
        end
      end
      sbh_pkg::ST_IDLE: begin
        if (msg_valid) begin
          absorb = msg.byte_valid;
          if (msg.byte_valid && fill == 6'd63) begin
            state_next = sbh_pkg::ST_LOAD;
          end else if (msg.end_of_message) begin
            state_next = sbh_pkg::ST_PAD;
          end
        end
      end
      sbh_pkg::ST_PAD: begin
        absorb = 1'b1;
        if (!marked) begin
          absorb_byte = sbh_pkg::PAD_BYTE;
          pad_mark    = 1'b1;
        end else if (fill != sbh_pkg::LEN_POS && !len_phase) begin
          absorb_byte = 8'h00;
        end else begin
          absorb_byte = len[63:56];
          pad_len     = 1'b1;
        end
        if (fill == 6'd63) begin
          state_next = sbh_pkg::ST_LOAD;
        end
      end
      sbh_pkg::ST_LOAD: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd16) begin
          cnt_next   = '0;
          state_next = sbh_pkg::ST_ROUND;
        end
      end
      sbh_pkg::ST_ROUND: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) begin
          state_next = sbh_pkg::ST_FINAL;
        end
      end
      sbh_pkg::ST_FINAL: begin
        ch_we    = rd_vld;
        ch_waddr = rd_idx[2:0];
        ch_wdata = ch_rdata + v[0];
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd8) begin
          cnt_next = '0;
          if (!finishing) begin
            state_next = sbh_pkg::ST_IDLE;
          end else if (len_phase) begin
            state_next = sbh_pkg::ST_OUT_RD;
          end else begin
            state_next = sbh_pkg::ST_PAD;
          end
        end
      end
      sbh_pkg::ST_OUT_RD: begin
        ch_raddr   = oc;
        state_next = sbh_pkg::ST_OUT_LD;
      end
      sbh_pkg::ST_OUT_LD: begin
        ch_we      = 1'b1;
        ch_waddr   = oc;
        ch_wdata   = sbh_pkg::INIT_H[oc];
        state_next = sbh_pkg::ST_OUT_HOLD;
      end
      sbh_pkg::ST_OUT_HOLD: begin
        if (!dig_stall) begin
          state_next = (oc == 3'd7) ? sbh_pkg::ST_IDLE : sbh_pkg::ST_OUT_RD;
        end
      end
      default: begin
        state_next = sbh_pkg::ST_INIT;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      fill      <= '0;
      len       <= '0;
      marked    <= 1'b0;
      len_phase <= 1'b0;
      finishing <= 1'b0;
      oc        <= '0;
      dig_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      cnt    <= cnt_next;
      rd_vld <= (state == sbh_pkg::ST_LOAD && cnt[5:4] == 2'b00) ||
                (state == sbh_pkg::ST_FINAL && cnt[5:3] == 3'b000);
      if (absorb) begin
        fill <= fill + 6'd1;
      end
      if (state == sbh_pkg::ST_IDLE && msg_valid) begin
        if (msg.byte_valid) begin
          len <= len + 64'd8;
        end
        if (msg.end_of_message) begin
          finishing <= 1'b1;
        end
      end
      if (pad_mark) begin
        marked <= 1'b1;
      end
      if (pad_len) begin
        len       <= {len[55:0], 8'h00};
        len_phase <= 1'b1;
      end
      if (state == sbh_pkg::ST_FINAL && cnt == 6'd8 && finishing && len_phase) begin
        finishing <= 1'b0;
        marked    <= 1'b0;
        len_phase <= 1'b0;
      end
      if (state == sbh_pkg::ST_OUT_LD) begin
        dig_valid <= 1'b1;
      end
      if (state == sbh_pkg::ST_OUT_HOLD && !dig_stall) begin
        dig_valid <= 1'b0;
        oc        <= oc + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt[3:0];
    if (absorb) begin
      pend <= {pend[15:0], absorb_byte};
    end
    case (state)
      sbh_pkg::ST_LOAD: begin
        if (rd_vld) begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= blk_rdata;
          if (!rd_idx[3]) begin
            for (int i = 0; i < 7; i++) begin
              v[i] <= v[i+1];
            end
            v[7] <= ch_rdata;
          end
        end
      end
      sbh_pkg::ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= w_new;
        v[7]  <= v[6];
        v[6]  <= v[5];
        v[5]  <= v[4];
        v[4]  <= v[3] + t1;
        v[3]  <= v[2];
        v[2]  <= v[1];
        v[1]  <= v[0];
        v[0]  <= t1 + t2;
      end
      sbh_pkg::ST_FINAL: begin
        if (rd_vld) begin
          for (int i = 0; i < 7; i++) begin
            v[i] <= v[i+1];
          end
        end
      end
      sbh_pkg::ST_OUT_LD: begin
        dig.digest_word <= ch_rdata;
        dig.word_index  <= oc;
        dig.last_word   <= (oc == 3'd7);
      end
      default: begin
      end
    endcase
  end

endmodule
